/* design/tvx_pkg.sv */
// Shared types and constants for the toy VM instruction execute block.
// Used by tvx_front, tvx_queue, tvx_back and the top level.
package tvx_pkg;

  localparam int REG_COUNT   = 16;
  localparam int MEM_BYTES   = 4096;
  localparam int INSTR_BYTES = 9;

  localparam int REG_AW = $clog2(REG_COUNT);
  localparam int MEM_AW = $clog2(MEM_BYTES);

  // decoded-word queue between front and back; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [REG_AW-1:0] REG_PC  = REG_AW'(0);
  localparam logic [REG_AW-1:0] REG_ACC = REG_AW'(1);
  localparam logic [REG_AW-1:0] REG_B   = REG_AW'(2);

  localparam logic [7:0] OPC_NUL = 8'd0;
  localparam logic [7:0] OPC_ADD = 8'd1;
  localparam logic [7:0] OPC_INV = 8'd2;
  localparam logic [7:0] OPC_OR  = 8'd3;
  localparam logic [7:0] OPC_AND = 8'd4;
  localparam logic [7:0] OPC_SL  = 8'd5;
  localparam logic [7:0] OPC_SR  = 8'd6;
  localparam logic [7:0] OPC_LT  = 8'd7;
  localparam logic [7:0] OPC_JMP = 8'd8;
  localparam logic [7:0] OPC_CJP = 8'd9;
  localparam logic [7:0] OPC_SET = 8'd10;
  localparam logic [7:0] OPC_MV  = 8'd11;
  localparam logic [7:0] OPC_LD  = 8'd12;
  localparam logic [7:0] OPC_STR = 8'd13;
  localparam logic [7:0] OPC_HLT = 8'd14;

  localparam logic [2:0] ST_ADVANCED  = 3'd0;
  localparam logic [2:0] ST_JUMPED    = 3'd1;
  localparam logic [2:0] ST_HALTED    = 3'd2;
  localparam logic [2:0] ST_NULL      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;
  localparam logic [2:0] ST_PC_BEYOND = 3'd6;

  typedef enum logic [3:0] {
    OP_NUL, OP_ADD, OP_INV, OP_OR, OP_AND, OP_SL, OP_SR, OP_LT,
    OP_JMP, OP_CJP, OP_SET, OP_MV, OP_LD, OP_STR, OP_HLT, OP_UNK
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR, BK_RUN, BK_LOAD
  } bk_state_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [31:0] operand_x;
    logic [31:0] operand_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [31:0] accumulator;
  } out_word_t;

  typedef struct packed {
    op_t               op;
    logic              bad;
    logic [REG_AW-1:0] rx;
    logic [REG_AW-1:0] ry;
    logic [MEM_AW-1:0] maddr;
    logic [31:0]       imm;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t word;
  } q_head_t;

endpackage

/* design/toy_vm_instruction_execute.sv */
// Toy VM instruction execute, top level. Words pass the queue and the result register
// to out_valid; an in-range byte load adds a registered memory read. Throughput: one
// word per cycle while out_stall is low; an in-range load holds the back end in
// BK_LOAD. Reset: synchronous, active low; afterwards a clear of the data memory
// (4096 bytes) runs with in_stall high. Registers and counter reset to zero.
module toy_vm_instruction_execute import tvx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic    busy;
  logic    q_full;
  logic    push;
  dec_t    push_word;
  logic    pop;
  q_head_t q_head;

  tvx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .busy      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  tvx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head)
  );

  tvx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/tvx_front.sv */
// Front end: takes input words, decodes the opcode and range-checks operands.
// Depends on tvx_pkg; feeds tvx_queue.
module tvx_front import tvx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     busy,
  input  logic     q_full,
  output logic     push,
  output dec_t     push_word
);

  logic x_reg_bad;
  logic y_reg_bad;
  logic x_mem_bad;
  logic seen_r;
  logic seen_nxt;

  assign in_stall = busy || q_full;
  assign push     = in_valid && !in_stall;

  assign x_reg_bad = in_data.operand_x >= 32'(REG_COUNT);
  assign y_reg_bad = in_data.operand_y >= 32'(REG_COUNT);
  assign x_mem_bad = in_data.operand_x >= 32'(MEM_BYTES);

  always_comb begin
    push_word.rx    = in_data.operand_x[REG_AW-1:0];
    push_word.ry    = in_data.operand_y[REG_AW-1:0];
    push_word.maddr = in_data.operand_x[MEM_AW-1:0];
    push_word.imm   = in_data.operand_y;
    push_word.bad   = 1'b0;
    case (in_data.opcode)
      OPC_NUL: push_word.op = OP_NUL;
      OPC_ADD: push_word.op = OP_ADD;
      OPC_INV: push_word.op = OP_INV;
      OPC_OR:  push_word.op = OP_OR;
      OPC_AND: push_word.op = OP_AND;
      OPC_SL:  push_word.op = OP_SL;
      OPC_SR:  push_word.op = OP_SR;
      OPC_LT:  push_word.op = OP_LT;
      OPC_JMP: push_word.op = OP_JMP;
      OPC_CJP: push_word.op = OP_CJP;
      OPC_SET: begin
        push_word.op  = OP_SET;
        push_word.bad = x_reg_bad;
      end
      OPC_MV: begin
        push_word.op  = OP_MV;
        push_word.bad = x_reg_bad || y_reg_bad;
      end
      OPC_LD: begin
        push_word.op  = OP_LD;
        push_word.bad = x_mem_bad;
      end
      OPC_STR: begin
        push_word.op  = OP_STR;
        push_word.bad = x_mem_bad;
      end
      OPC_HLT: push_word.op = OP_HLT;
      default: push_word.op = OP_UNK;
    endcase
  end

  // sticky flag: a word has entered since reset
  assign seen_nxt = seen_r || push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  a_no_push_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push)
    else $error("word taken during memory clear");

endmodule

/* design/tvx_queue.sv */
// Short FIFO of decoded words between front and back ends.
// Depends on tvx_pkg.
module tvx_queue import tvx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  dec_t    push_word,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  dec_t           buf_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == QCW'(QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.word  = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_word;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue pop while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCW'(QDEPTH) || pop))
    else $error("queue push while full");

endmodule

/* design/tvx_back.sv */
// Back end: register file, byte data memory, program counter and result register.
// Depends on tvx_pkg; pops decoded words from tvx_queue.
module tvx_back import tvx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_BYTES - 1);

  bk_state_t         state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]       rf_r [REG_COUNT];
  logic [7:0]        mem_r [MEM_BYTES];
  logic [7:0]        mem_rd_r;
  logic [31:0]       pc_r, pc_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r;

  dec_t              w;
  logic              out_free;
  logic              emit;
  logic              ld_issue;
  logic              rf_we;
  logic [REG_AW-1:0] rf_widx;
  logic [31:0]       rf_wval;
  logic              mem_we;
  logic [31:0]       a, b, rd_x;
  logic [31:0]       pc_eff, npc;
  logic [2:0]        st, st_fin;
  logic              adv;
  logic              beyond;
  logic [31:0]       acc;

  assign w         = q_head.word;
  assign out_free  = !out_valid_r || !out_stall;
  assign busy      = state_r == BK_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register 0 always reads as the program counter
  assign a    = rf_r[REG_ACC];
  assign b    = rf_r[REG_B];
  assign rd_x = (w.rx == REG_PC) ? pc_r : rf_r[w.rx];

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    pop         = 1'b0;
    emit        = 1'b0;
    ld_issue    = 1'b0;
    rf_we       = 1'b0;
    rf_widx     = REG_ACC;
    rf_wval     = a;
    mem_we      = 1'b0;
    pc_eff      = pc_r;
    st          = ST_ADVANCED;
    adv         = 1'b1;
    case (state_r)
      BK_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (q_head.valid && out_free) begin
          pop = 1'b1;
          if (w.op == OP_LD && !w.bad) begin
            ld_issue  = 1'b1;
            state_nxt = BK_LOAD;
          end else begin
            emit = 1'b1;
            case (w.op)
              OP_NUL: st = ST_NULL;
              OP_ADD: begin
                rf_we   = 1'b1;
                rf_wval = a + b;
              end
              OP_INV: begin
                rf_we   = 1'b1;
                rf_wval = ~a;
              end
              OP_OR: begin
                rf_we   = 1'b1;
                rf_wval = {31'd0, (a != '0) || (b != '0)};
              end
              OP_AND: begin
                rf_we   = 1'b1;
                rf_wval = {31'd0, (a != '0) && (b != '0)};
              end
              OP_SL: begin
                rf_we   = 1'b1;
                rf_wval = (|b[31:5]) ? '0 : a << b[4:0];
              end
              OP_SR: begin
                rf_we   = 1'b1;
                rf_wval = (|b[31:5]) ? '0 : a >> b[4:0];
              end
              OP_LT: begin
                rf_we   = 1'b1;
                rf_wval = {31'd0, a < b};
              end
              OP_JMP: begin
                pc_eff = b;
                st     = ST_JUMPED;
                adv    = 1'b0;
              end
              OP_CJP: begin
                if (a != '0) begin
                  pc_eff = b;
                  st     = ST_JUMPED;
                  adv    = 1'b0;
                end
              end
              OP_SET, OP_MV: begin
                if (w.bad) begin
                  st  = ST_BAD_INDEX;
                  adv = 1'b0;
                end else begin
                  rf_we   = 1'b1;
                  rf_widx = (w.op == OP_SET) ? w.rx : w.ry;
                  rf_wval = (w.op == OP_SET) ? w.imm : rd_x;
                end
              end
              OP_LD: begin
                // only out-of-range loads land here
                st  = ST_BAD_INDEX;
                adv = 1'b0;
              end
              OP_STR: begin
                if (w.bad) begin
                  st  = ST_BAD_INDEX;
                  adv = 1'b0;
                end else begin
                  mem_we = 1'b1;
                end
              end
              OP_HLT: begin
                st  = ST_HALTED;
                adv = 1'b0;
              end
              default: st = ST_UNKNOWN;
            endcase
          end
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          emit      = 1'b1;
          rf_we     = 1'b1;
          rf_wval   = {24'd0, mem_rd_r};
          state_nxt = BK_RUN;
        end
      end
      default: state_nxt = BK_CLEAR;
    endcase

    // a counter above MEM_BYTES wins over every other status
    beyond = pc_eff > 32'(MEM_BYTES);
    st_fin = beyond ? ST_PC_BEYOND : st;
    npc    = (!beyond && adv) ? pc_eff + 32'(INSTR_BYTES) : pc_eff;
    pc_nxt = emit ? npc : pc_r;
    acc    = (rf_we && rf_widx == REG_ACC) ? rf_wval : a;
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else if (rf_we) begin
      rf_r[rf_widx] <= rf_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.status      <= st_fin;
      out_data_r.next_pc     <= npc;
      out_data_r.accumulator <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem_r[clr_cnt_r] <= 8'd0;
    end else if (mem_we) begin
      mem_r[w.maddr] <= a[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_issue) begin
      mem_rd_r <= mem_r[w.maddr];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("pending result overwritten");

  a_load_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LOAD) |-> $past(ld_issue))
    else $error("load wait without a load issued");

  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!pop && !emit))
    else $error("word executed during memory clear");

endmodule
